// ----- rtl/fha_pkg.sv -----
// ----------------------------------------------------------------------------
// fha_pkg
// Shared types and constants for the frame heap allocator.
// ----------------------------------------------------------------------------
package fha_pkg;

	localparam int unsigned FRAME_DEPTH_DEF = 16;
	localparam logic [31:0] ROOT_TAG = 32'h1111_1111;
	localparam logic [31:0] RECORD_BYTES = 32'd16;
	localparam logic [3:0] RECORD_ALIGN_LOG2 = 4'd2;
	localparam logic [31:0] HEAP_LENGTH_RST = 32'd65536;

	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_FREE = 3'd1,
		OP_RESIZE = 3'd2,
		OP_TRIM = 3'd3,
		OP_LARGEST = 3'd4,
		OP_PUSH = 3'd5,
		OP_POP = 3'd6,
		OP_NONE = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_COMMIT,
		ST_RD,
		ST_CMP,
		ST_DONE
	} state_t;

	// ALU operation selects
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_AND
	} alu_op_t;

	localparam logic REG_HEAP_BASE = 1'b0;
	localparam logic REG_HEAP_LENGTH = 1'b1;

	function automatic logic [32:0] mask33(input logic [3:0] lg);
		logic [32:0] m;
		m = (33'd1 << lg) - 33'd1;
		return m;
	endfunction

endpackage

// ----- rtl/frame_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// frame_heap_allocator
// Double-ended bump allocator with a tagged frame stack.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// command  in         start & !busy       operation..tag
// result   out        done (one cycle)    value, ok
// config   in         cfg_valid&cfg_ready cfg_index, cfg_data
//
// Busy from the command being taken through ST_EXEC, ST_CHECK, ST_COMMIT and
// ST_DONE (a pop that needs no search: ST_EXEC, ST_CMP, ST_DONE); done is
// registered from ST_DONE, so the result word is strobed as busy falls. Pop
// with a tag walks the frame memory one entry at a time via ST_RD and ST_CMP.
// Reset and any config write re-initialize the heap marks; frame memory has
// no reset. The receiver cannot stall: done is a single-cycle strobe.
module frame_heap_allocator
	import fha_pkg::*;
#(
	parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [31:0] size,
	input  logic [3:0]  align_log2,
	input  logic        from_top,
	input  logic [31:0] address,
	input  logic        free_head,
	input  logic        free_tail,
	input  logic [31:0] tag,
	output logic        done,
	output logic [31:0] value,
	output logic        ok,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int unsigned IW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_DEPTH);

	state_t state_q, state_d;

	logic [31:0] base_q, length_q;
	logic [31:0] top_q, bot_q, ftag_q, lim_q, live_q;
	logic [CW-1:0] cnt_q, idx_q;

	op_t op_q;
	logic [31:0] size_q, addr_q, tag_q;
	logic [3:0] lg_q;
	logic ftop_q, fhead_q, ftail_q;
	logic [33:0] r1_q, r2_q;

	logic [31:0] mem_tag [FRAME_DEPTH];
	logic [31:0] mem_top [FRAME_DEPTH];
	logic [31:0] mem_bot [FRAME_DEPTH];
	logic [31:0] rd_tag_q, rd_top_q, rd_bot_q;

	logic mem_we;
	logic [IW-1:0] wr_idx, rd_idx;
	logic rd_en;

	alu_op_t alu_op;
	logic [32:0] alu_a, alu_b;
	logic [33:0] alu_y;

	fha_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

	logic cfg_wr;
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign busy = (state_q != ST_IDLE);

	logic [32:0] m33;
	logic [3:0] lg_eff;
	assign lg_eff = (op_q == OP_PUSH) ? RECORD_ALIGN_LOG2 : lg_q;
	assign m33 = mask33(lg_eff);
	logic [31:0] gap;
	assign gap = top_q - bot_q;
	logic [31:0] asz;
	assign asz = (op_q == OP_PUSH) ? RECORD_BYTES : size_q;

	// Phase 1 (ST_EXEC): padded = size + mask (33 bits), or resize diff, etc.
	// Phase 2 (ST_CHECK) and phase 3 (ST_COMMIT): second and third ALU passes.
	always_comb begin
		alu_op = ALU_ADD;
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			ST_EXEC: begin
				unique case (op_q)
					OP_ALLOC, OP_PUSH: begin
						alu_a = {1'b0, asz};
						alu_b = m33;
					end
					OP_RESIZE: begin
						alu_op = ALU_SUB;
						alu_a = {1'b0, size_q};
						alu_b = {1'b0, bot_q - addr_q};
					end
					OP_LARGEST: begin
						alu_a = {1'b0, bot_q};
						alu_b = m33;
					end
					default: ;
				endcase
			end
			ST_CHECK: begin
				unique case (op_q)
					OP_ALLOC, OP_PUSH: begin
						alu_op = ALU_AND;
						alu_a = r1_q[32:0];
						alu_b = ~m33;
					end
					OP_LARGEST: begin
						alu_op = ALU_AND;
						alu_a = r1_q[32:0];
						alu_b = ~m33;
					end
					default: ;
				endcase
			end
			ST_COMMIT: begin
				unique case (op_q)
					OP_ALLOC, OP_PUSH: begin
						alu_a = {1'b0, ftop_q ? (top_q - r2_q[31:0]) : bot_q};
						alu_b = m33;
					end
					OP_LARGEST: begin
						alu_op = ALU_SUB;
						alu_a = {1'b0, top_q} & ~m33;
						alu_b = r2_q[32:0];
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_EXEC;
			ST_EXEC: begin
				priority if (op_q == OP_POP) state_d = ST_CMP;
				else state_d = ST_CHECK;
			end
			ST_CHECK: state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_DONE;
			ST_RD: state_d = ST_CMP;
			ST_CMP: begin
				priority if (tag_q == '0 || tag_q == ftag_q || idx_q == '0) state_d = ST_DONE;
				else if (rd_tag_q == tag_q) state_d = ST_DONE;
				else state_d = ST_RD;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic pad_ok, alloc_ok;
	assign pad_ok = !r2_q[32];
	assign alloc_ok = pad_ok && (gap >= r2_q[31:0]);
	logic push_ok;
	assign push_ok = (cnt_q < DEPTH_C) && alloc_ok;

	// memory control
	always_comb begin
		mem_we = (state_q == ST_COMMIT) && (op_q == OP_PUSH) && push_ok;
		wr_idx = cnt_q[IW-1:0];
		rd_en = (state_q == ST_IDLE && start) || (state_q == ST_RD);
		if (state_q == ST_IDLE) rd_idx = cnt_q[IW-1:0] - IW'(1);
		else rd_idx = idx_q[IW-1:0] - IW'(1);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_tag[wr_idx] <= ftag_q;
			mem_top[wr_idx] <= top_q;
			mem_bot[wr_idx] <= bot_q + r2_q[31:0];
		end
		if (rd_en) begin
			rd_tag_q <= mem_tag[rd_idx];
			rd_top_q <= mem_top[rd_idx];
			rd_bot_q <= mem_bot[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q <= op_t'(operation);
			size_q <= size;
			addr_q <= address;
			tag_q <= tag;
			lg_q <= align_log2;
			ftop_q <= from_top;
			fhead_q <= free_head;
			ftail_q <= free_tail;
		end
		if (state_q == ST_EXEC) r1_q <= alu_y;
		if (state_q == ST_CHECK) r2_q <= alu_y;
		if (state_q == ST_COMMIT) r1_q <= alu_y;
	end

	logic res_ok;
	logic [31:0] res_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q <= '0;
			length_q <= HEAP_LENGTH_RST;
			top_q <= HEAP_LENGTH_RST;
			lim_q <= HEAP_LENGTH_RST;
			bot_q <= RECORD_BYTES;
			ftag_q <= ROOT_TAG;
			live_q <= HEAP_LENGTH_RST;
			cnt_q <= '0;
			idx_q <= '0;
			res_ok <= 1'b0;
			res_val <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				logic [31:0] nb, nl;
				nb = (cfg_index == REG_HEAP_BASE) ? cfg_data : base_q;
				nl = (cfg_index == REG_HEAP_LENGTH) ? cfg_data : length_q;
				base_q <= nb;
				length_q <= nl;
				top_q <= nb + nl;
				lim_q <= nb + nl;
				bot_q <= nb + RECORD_BYTES;
				ftag_q <= ROOT_TAG;
				live_q <= nl;
				cnt_q <= '0;
			end
			if (state_q == ST_IDLE && start) idx_q <= cnt_q;
			if (state_q == ST_EXEC) begin
				unique case (op_q)
					OP_FREE: begin
						if (ftail_q) top_q <= (cnt_q != '0) ? rd_top_q : lim_q;
						if (fhead_q) bot_q <= (cnt_q != '0) ? rd_bot_q : base_q + RECORD_BYTES;
						res_val <= '0;
						res_ok <= 1'b1;
					end
					OP_TRIM: begin
						if (top_q == lim_q) begin
							live_q <= bot_q - base_q;
							res_val <= bot_q - base_q;
							lim_q <= bot_q;
							top_q <= bot_q;
						end else res_val <= live_q;
						res_ok <= 1'b1;
					end
					default: begin
						res_ok <= 1'b0;
						res_val <= '0;
					end
				endcase
			end
			if (state_q == ST_CHECK && op_q == OP_RESIZE) begin
				if (addr_q <= bot_q && addr_q >= base_q + RECORD_BYTES &&
					(r1_q[33] || r1_q[31:0] == '0 || r1_q[31:0] <= gap)) begin
					bot_q <= addr_q + size_q;
					res_val <= size_q;
					res_ok <= 1'b1;
				end
			end
			if (state_q == ST_COMMIT) begin
				unique case (op_q)
					OP_ALLOC: if (alloc_ok) begin
						if (ftop_q) top_q <= top_q - r2_q[31:0];
						else bot_q <= bot_q + r2_q[31:0];
						res_val <= alu_y[31:0] & ~m33[31:0];
						res_ok <= 1'b1;
					end
					OP_PUSH: if (push_ok) begin
						bot_q <= bot_q + r2_q[31:0];
						cnt_q <= cnt_q + CW'(1);
						ftag_q <= tag_q;
						res_ok <= 1'b1;
					end
					OP_LARGEST: begin
						res_val <= alu_y[33] || alu_y[32:0] == '0 ? '0 : alu_y[31:0];
						res_ok <= 1'b1;
					end
					default: ;
				endcase
			end
			if (state_q == ST_CMP) begin
				if (tag_q == '0) begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
						ftag_q <= rd_tag_q;
						top_q <= rd_top_q;
						bot_q <= rd_bot_q;
						res_ok <= 1'b1;
					end else res_ok <= 1'b0;
					res_val <= '0;
				end else if (tag_q == ftag_q) begin
					res_ok <= 1'b1;
					res_val <= '0;
				end else if (idx_q == '0) begin
					res_ok <= 1'b0;
					res_val <= '0;
				end else if (rd_tag_q == tag_q) begin
					cnt_q <= idx_q - CW'(1);
					ftag_q <= rd_tag_q;
					top_q <= rd_top_q;
					bot_q <= rd_bot_q;
					res_ok <= 1'b1;
					res_val <= '0;
				end else begin
					idx_q <= idx_q - CW'(1);
				end
			end
		end
	end

	// In ST_CMP the read data holds entry idx_q-1; the first one is fetched
	// when the command is taken, ST_RD fetches the next one down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_DONE);
		end
	end

	assign value = res_val;
	assign ok = res_ok;

	property p_done_one;
		@(posedge clk) disable iff (!arst_n) done |=> !done;
	endproperty
	assert property (p_done_one) else $error("done longer than one cycle");

	property p_cnt_range;
		@(posedge clk) disable iff (!arst_n) cnt_q <= DEPTH_C;
	endproperty
	assert property (p_cnt_range) else $error("frame count overflow");

	property p_busy_start;
		@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy;
	endproperty
	assert property (p_busy_start) else $error("command not taken");
endmodule

// ----- rtl/fha_alu.sv -----
// ----------------------------------------------------------------------------
// fha_alu
// Shared 33-bit add / subtract / mask unit used by the sequencer.
// ----------------------------------------------------------------------------
module fha_alu
	import fha_pkg::*;
(
	input  alu_op_t     op,
	input  logic [32:0] a,
	input  logic [32:0] b,
	output logic [33:0] y
);
	always_comb begin
		unique case (op)
			ALU_ADD: y = {1'b0, a} + {1'b0, b};
			ALU_SUB: y = {1'b0, a} - {1'b0, b};
			ALU_AND: y = {1'b0, a & b};
			default: y = '0;
		endcase
	end
endmodule

// ----- test/tb_frame_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_frame_heap_allocator
// Self-checking bench for the frame heap allocator: a built-in predictor
// tracks heap marks and the frame stack, and every result word is checked
// against it. Directed cases first, then random phases under several heap
// settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_frame_heap_allocator;
	import fha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = FRAME_DEPTH_DEF;

	typedef struct {
		op_t         op;
		logic [31:0] size;
		logic [3:0]  lg;
		logic        top_end;
		logic [31:0] addr;
		logic        head;
		logic        tail;
		logic [31:0] tag;
	} cmd_t;

	typedef struct {
		logic [31:0] value;
		logic        ok;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = '0;
	logic [31:0] size = '0;
	logic [3:0]  align_log2 = '0;
	logic        from_top = 1'b0;
	logic [31:0] address = '0;
	logic        free_head = 1'b0;
	logic        free_tail = 1'b0;
	logic [31:0] tag = '0;
	logic        done;
	logic [31:0] value;
	logic        ok;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	// predictor state
	logic [31:0] h_base, h_len, h_top, h_bot, h_tag, h_limit, h_live;
	logic [31:0] fr_tags[DEPTH], fr_tops[DEPTH], fr_bots[DEPTH];
	int          fr_count;

	res_t        expected_q[$];
	int          errors = 0;
	int          n_items = 0, n_results = 0, n_ok = 0;
	int          n_push_ok = 0, n_pop_ok = 0, n_cfg = 0;
	int          gap_pct = 0;

	frame_heap_allocator uut (.*);

	always #6 clk = ~clk;

	initial begin
		#20ms;
		$display("tb_frame_heap_allocator: done, errors");
		$finish;
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [63:0] round_up(input logic [63:0] v, input logic [3:0] lg);
		logic [63:0] a;
		a = 64'd1 << lg;
		return (v + a - 64'd1) & ~(a - 64'd1);
	endfunction

	function automatic void heap_init();
		h_top = h_base + h_len;
		h_limit = h_top;
		h_bot = h_base + RECORD_BYTES;
		h_tag = ROOT_TAG;
		h_live = h_len;
		fr_count = 0;
	endfunction

	function automatic bit carve(input logic [31:0] sz, input logic [3:0] lg,
			input logic top_end, output logic [31:0] addr);
		logic [63:0] padded;
		logic [31:0] st;
		padded = round_up({32'd0, sz}, lg);
		addr = '0;
		if (padded > 64'hFFFF_FFFF) return 0;
		if (h_top - h_bot < padded[31:0]) return 0;
		if (top_end) begin
			h_top = h_top - padded[31:0];
			st = h_top;
		end else begin
			st = h_bot;
			h_bot = h_bot + padded[31:0];
		end
		addr = round_up({32'd0, st}, lg);
		return 1;
	endfunction

	function automatic res_t heap_step(input cmd_t c);
		res_t r;
		logic [31:0] a;
		logic [63:0] lo, hi;
		longint diff;
		int i;
		r.value = '0;
		r.ok = 1'b0;
		case (c.op)
			OP_ALLOC: begin
				r.ok = carve(c.size, c.lg, c.top_end, a);
				r.value = r.ok ? a : 32'd0;
			end
			OP_FREE: begin
				if (c.tail) h_top = fr_count ? fr_tops[fr_count-1] : h_limit;
				if (c.head) h_bot = fr_count ? fr_bots[fr_count-1] : h_base + RECORD_BYTES;
				r.ok = 1'b1;
			end
			OP_RESIZE: begin
				if (c.addr <= h_bot && c.addr >= h_base + RECORD_BYTES) begin
					diff = longint'({32'd0, c.size}) - longint'({32'd0, h_bot - c.addr});
					if (diff <= 0 || diff <= longint'({32'd0, h_top - h_bot})) begin
						h_bot = c.addr + c.size;
						r.value = c.size;
						r.ok = 1'b1;
					end
				end
			end
			OP_TRIM: begin
				if (h_top == h_limit) begin
					h_live = h_bot - h_base;
					h_limit = h_bot;
					h_top = h_bot;
				end
				r.value = h_live;
				r.ok = 1'b1;
			end
			OP_LARGEST: begin
				lo = round_up({32'd0, h_bot}, c.lg);
				hi = {32'd0, h_top} & ~((64'd1 << c.lg) - 64'd1);
				r.value = hi > lo ? 32'(hi - lo) : 32'd0;
				r.ok = 1'b1;
			end
			OP_PUSH: begin
				if (fr_count < DEPTH && carve(RECORD_BYTES, RECORD_ALIGN_LOG2, 1'b0, a)) begin
					fr_tags[fr_count] = h_tag;
					fr_tops[fr_count] = h_top;
					fr_bots[fr_count] = h_bot;
					fr_count++;
					h_tag = c.tag;
					r.ok = 1'b1;
				end
			end
			OP_POP: begin
				if (c.tag == 0) begin
					if (fr_count > 0) begin
						fr_count--;
						h_tag = fr_tags[fr_count];
						h_top = fr_tops[fr_count];
						h_bot = fr_bots[fr_count];
						r.ok = 1'b1;
					end
				end else if (h_tag == c.tag) begin
					r.ok = 1'b1;
				end else begin
					for (i = fr_count - 1; i >= 0; i--) begin
						if (fr_tags[i] == c.tag) begin
							h_tag = fr_tags[i];
							h_top = fr_tops[i];
							h_bot = fr_bots[i];
							fr_count = i;
							r.ok = 1'b1;
							break;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// result checker: done is a one-cycle strobe
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result value=%h ok=%b", value, ok));
			end else begin
				res_t e;
				e = expected_q.pop_front();
				if (value !== e.value)
					report($sformatf("value got %h want %h", value, e.value));
				if (ok !== e.ok)
					report($sformatf("ok got %b want %b", ok, e.ok));
				if (e.ok) n_ok++;
			end
		end
	end

	task automatic send(input cmd_t c);
		res_t r;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= c.op;
		size <= c.size;
		align_log2 <= c.lg;
		from_top <= c.top_end;
		address <= c.addr;
		free_head <= c.head;
		free_tail <= c.tail;
		tag <= c.tag;
		do @(posedge clk); while (busy);
		r = heap_step(c);
		expected_q.push_back(r);
		n_items++;
		if (c.op == OP_PUSH && r.ok) n_push_ok++;
		if (c.op == OP_POP && r.ok) n_pop_ok++;
	endtask

	function automatic cmd_t mk(input op_t op, input logic [31:0] sz = 0,
			input logic [3:0] lg = 0, input logic top_end = 0, input logic [31:0] addr = 0,
			input logic head = 0, input logic tail = 0, input logic [31:0] tg = 0);
		cmd_t c;
		c.op = op; c.size = sz; c.lg = lg; c.top_end = top_end;
		c.addr = addr; c.head = head; c.tail = tail; c.tag = tg;
		return c;
	endfunction

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);
	endtask

	// register writes only with the block idle
	task automatic write_reg(input logic idx, input logic [31:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_HEAP_BASE) h_base = data;
		else h_len = data;
		heap_init();
		n_cfg++;
		@(posedge clk);
	endtask

	task automatic test_alloc();
		send(mk(OP_ALLOC, 32'd0));
		send(mk(OP_ALLOC, 32'd5, 4'd3));
		send(mk(OP_ALLOC, 32'd100, 4'd4, 1'b1));
		send(mk(OP_ALLOC, 32'hFFFF_FFFF, 4'd0));
		send(mk(OP_ALLOC, 32'hFFFF_FFF0, 4'd15, 1'b1));
		send(mk(OP_LARGEST, 0, 4'd15));
		send(mk(OP_LARGEST, 0, 4'd0));
		send(mk(OP_NONE, 32'hFFFF_FFFF, 4'd15, 1, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF));
	endtask

	task automatic test_resize_free();
		send(mk(OP_RESIZE, 32'd64, 0, 0, h_bot - 32'd8));
		send(mk(OP_RESIZE, 32'd0, 0, 0, h_bot));
		send(mk(OP_RESIZE, 32'hFFFF_FFFF, 0, 0, h_bot));
		send(mk(OP_RESIZE, 32'd4, 0, 0, h_bot + 32'd4));
		send(mk(OP_RESIZE, 32'd4, 0, 0, 32'd0));
		send(mk(OP_FREE, 0, 0, 0, 0, 1'b0, 1'b1));
		send(mk(OP_FREE, 0, 0, 0, 0, 1'b1, 1'b0));
		send(mk(OP_ALLOC, 32'd40, 4'd2, 1'b1));
		send(mk(OP_TRIM));
		send(mk(OP_FREE, 0, 0, 0, 0, 1'b1, 1'b1));
		send(mk(OP_TRIM));
		send(mk(OP_FREE));
	endtask

	task automatic test_frames();
		for (int i = 0; i < DEPTH + 1; i++) send(mk(OP_PUSH, 0, 0, 0, 0, 0, 0, 32'd100 + i));
		send(mk(OP_FREE, 0, 0, 0, 0, 1'b1, 1'b1));
		send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 32'd100 + DEPTH - 1));
		send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 32'd105));
		send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 32'hDEAD_0001));
		send(mk(OP_POP, 0, 0, 0, 0, 0, 0, ROOT_TAG));
		send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 32'd0));
		send(mk(OP_PUSH, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 32'd0));
		send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 32'd0));
	endtask

	task automatic test_config_edges();
		write_reg(REG_HEAP_LENGTH, 32'd16);
		send(mk(OP_ALLOC, 32'd1));
		send(mk(OP_PUSH, 0, 0, 0, 0, 0, 0, 32'd7));
		send(mk(OP_LARGEST, 0, 4'd1));
		send(mk(OP_TRIM));
		write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
		write_reg(REG_HEAP_LENGTH, 32'h0000_0400);
		send(mk(OP_ALLOC, 32'h80, 4'd4, 1'b1));
		send(mk(OP_ALLOC, 32'h10, 4'd15));
		send(mk(OP_LARGEST, 0, 4'd4));
		send(mk(OP_RESIZE, 32'h300, 0, 0, h_bot));
		write_reg(REG_HEAP_LENGTH, 32'hFFFF_FFFF);
		send(mk(OP_ALLOC, 32'h8000_0000, 4'd15, 1'b1));
		send(mk(OP_LARGEST, 0, 4'd15));
	endtask

	function automatic logic [31:0] pick_tag();
		int k;
		k = $urandom_range(9);
		if (k == 0) return $urandom();
		if (k == 1) return ROOT_TAG;
		return $urandom_range(6, 1);
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int k;
		c = mk(OP_NONE, $urandom(), 4'($urandom()), 1'($urandom()), $urandom(),
			1'($urandom()), 1'($urandom()), pick_tag());
		k = $urandom_range(99);
		if (k < 30) begin
			c.op = OP_ALLOC;
			if ($urandom_range(9) != 0) c.size = $urandom_range(300);
			if ($urandom_range(3) != 0) c.lg = $urandom_range(6);
		end else if (k < 42) c.op = OP_FREE;
		else if (k < 54) begin
			c.op = OP_RESIZE;
			if ($urandom_range(7) != 0) c.addr = h_bot - $urandom_range(64);
			if ($urandom_range(7) != 0) c.size = $urandom_range(160);
		end else if (k < 58) c.op = OP_TRIM;
		else if (k < 66) c.op = OP_LARGEST;
		else if (k < 82) c.op = OP_PUSH;
		else if (k < 97) begin
			c.op = OP_POP;
			if ($urandom_range(2) == 0) c.tag = 0;
		end
		return c;
	endfunction

	task automatic test_random(input int n, input int gap);
		gap_pct = gap;
		for (int i = 0; i < n; i++) begin
			send(rand_cmd());
			// once, halfway through, let the heap settle completely before going on
			if (i == n / 2) drain();
		end
		gap_pct = 0;
	endtask

	initial begin
		h_base = '0;
		h_len = HEAP_LENGTH_RST;
		heap_init();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alloc();
		test_resize_free();
		test_frames();
		test_config_edges();

		write_reg(REG_HEAP_BASE, 32'h0001_0000);
		write_reg(REG_HEAP_LENGTH, 32'h0000_2000);
		test_random(400, 0);
		write_reg(REG_HEAP_BASE, 32'd0);
		write_reg(REG_HEAP_LENGTH, 32'h0000_0800);
		test_random(400, 70);
		write_reg(REG_HEAP_BASE, 32'hFFFF_F000);
		write_reg(REG_HEAP_LENGTH, 32'h0000_4000);
		test_random(400, 12);
		write_reg(REG_HEAP_LENGTH, HEAP_LENGTH_RST);
		test_random(400, 0);

		drain();
		$display("Covered %0d commands (%0d results, %0d ok) over %0d register writes;",
			n_items, n_results, n_ok, n_cfg);
		$display("frame pushes ok %0d, pops ok %0d, mismatches %0d",
			n_push_ok, n_pop_ok, errors);
		if (errors == 0 && expected_q.size() == 0)
			$display("tb_frame_heap_allocator: done, clean");
		else
			$display("tb_frame_heap_allocator: done, errors");
		$finish;
	end
endmodule
